// ===== src/gic_pkg.sv =====
// Package for the greedy interval cover block.
// Holds the shared constants, result status codes, sequencer states and the
// scan-unit control struct. It depends on nothing.
package gic_pkg;

    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int COORD_BITS_DEF   = 17;

    // Width and reset value of the target register
    localparam int                  TARGET_BITS  = 16;
    localparam logic [TARGET_BITS-1:0] TARGET_RESET = 16'd1;

    // The cover run holds the start segment plus at most RESULT_CAP-1 steps
    localparam int RESULT_CAP = 64;
    localparam int CAP_BITS   = $clog2(RESULT_CAP);

    localparam int STATUS_BITS = 2;
    localparam logic [STATUS_BITS-1:0] ST_COVER    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_NONE     = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_OVERFLOW = 2'd2;

    typedef enum logic [2:0] {
        S_LOAD,
        S_CHECK,
        S_SCAN,
        S_DECIDE,
        S_EMIT_START,
        S_EMIT_RD,
        S_EMIT_WR,
        S_FAIL
    } state_t;

    // Control of the shared compare unit
    typedef struct packed {
        logic clear;   // drop the current best candidate
        logic sample;  // candidate data on the unit's inputs is valid
    } scan_ctl_t;

endpackage

// ===== src/gic_if.sv =====
// Channel interfaces of the greedy interval cover block.
// seg_if carries input segments, cover_if carries cover results.
// Depends on gic_pkg for the status width.
interface seg_if #(
    parameter int COORD_BITS = gic_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] seg_left;
    logic signed [COORD_BITS-1:0] seg_right;
    logic                         last_segment;

    modport source (output valid, output seg_left, output seg_right,
                    output last_segment, input ready);
    modport sink   (input valid, input seg_left, input seg_right,
                    input last_segment, output ready);
endinterface

interface cover_if #(
    parameter int COORD_BITS = gic_pkg::COORD_BITS_DEF
);
    logic                              valid;
    logic                              ready;
    logic signed [COORD_BITS-1:0]      cover_left;
    logic signed [COORD_BITS-1:0]      cover_right;
    logic [gic_pkg::STATUS_BITS-1:0]   status;
    logic                              last_result;

    modport source (output valid, output cover_left, output cover_right,
                    output status, output last_result, input ready);
    modport sink   (input valid, input cover_left, input cover_right,
                    input status, input last_result, output ready);
endinterface

// ===== src/gic_scan.sv =====
// Shared compare unit of the greedy interval cover block.
// Keeps the best candidate of one scan pass. Depends on gic_pkg.
module gic_scan #(
    parameter int COORD_BITS = gic_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  gic_pkg::scan_ctl_t           ctl,
    input  logic signed [COORD_BITS-1:0] reach,
    input  logic signed [COORD_BITS-1:0] cand_left,
    input  logic signed [COORD_BITS-1:0] cand_right,
    output logic                         have,
    output logic signed [COORD_BITS-1:0] best_left,
    output logic signed [COORD_BITS-1:0] best_right
);

    logic                         have_reg;
    logic                         have_next;
    logic signed [COORD_BITS-1:0] best_left_reg;
    logic signed [COORD_BITS-1:0] best_left_next;
    logic signed [COORD_BITS-1:0] best_right_reg;
    logic signed [COORD_BITS-1:0] best_right_next;
    logic                         take;

    // Take a reachable candidate with larger right, larger left on a tie
    always_comb
    begin
        take = ctl.sample && (cand_left <= reach) &&
               (!have_reg || (cand_right > best_right_reg) ||
                ((cand_right == best_right_reg) && (cand_left > best_left_reg)));
        have_next       = have_reg;
        best_left_next  = best_left_reg;
        best_right_next = best_right_reg;
        if (ctl.clear)
        begin
            have_next = 1'b0;
        end
        else if (take)
        begin
            have_next       = 1'b1;
            best_left_next  = cand_left;
            best_right_next = cand_right;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
        end
        else
        begin
            have_reg <= have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_left_reg  <= best_left_next;
        best_right_reg <= best_right_next;
    end

    assign have       = have_reg;
    assign best_left  = best_left_reg;
    assign best_right = best_right_reg;

endmodule

// ===== src/greedy_interval_cover.sv =====
// Greedy minimum interval cover: load segments one beat per cycle, then cover [0,target_end].
// Throughput: one non-final segment beat per cycle; the input is held off from the final
// beat until the last result of the run is loaded. Each greedy step is a reach check, a scan
// with one store read per cycle through the shared compare unit and a decision; then a final
// reach check, the start beat, and a cover read and write per further beat, plus stalls.
// Reset (rst_n, async, active low) clears the set, sets target_end to 1, keeps the memories.
module greedy_interval_cover #(
    parameter int MAX_SEGMENTS = gic_pkg::MAX_SEGMENTS_DEF,
    parameter int COORD_BITS   = gic_pkg::COORD_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [gic_pkg::TARGET_BITS-1:0]  cfg_wr_data,
    seg_if.sink                              seg,
    cover_if.source                          result
);

    // Store address width and a count wide enough to hold MAX_SEGMENTS itself
    localparam int AW    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    // Signed compare width that holds both a coordinate and the unsigned target
    localparam int CMP_W = (COORD_BITS > gic_pkg::TARGET_BITS) ?
                           COORD_BITS : gic_pkg::TARGET_BITS + 1;
    localparam int CB    = gic_pkg::CAP_BITS;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    gic_pkg::state_t                  state_reg, state_next;
    logic [gic_pkg::TARGET_BITS-1:0]  target_reg;
    logic [CNT_W-1:0]                 count_reg, count_next;
    logic                             start_found_reg, start_found_next;
    logic signed [COORD_BITS-1:0]     start_left_reg, start_left_next;
    logic signed [COORD_BITS-1:0]     start_right_reg, start_right_next;
    logic                             ovfl_reg, ovfl_next;
    logic signed [COORD_BITS-1:0]     reach_reg, reach_next;
    logic [CB-1:0]                    n_reg, n_next;
    logic [CB-1:0]                    k_reg, k_next;
    logic [CNT_W-1:0]                 scan_idx_reg, scan_idx_next;
    logic                             rd_pend_reg, rd_pend_next;

    // Output register
    logic                             out_valid_reg, out_valid_next;
    logic signed [COORD_BITS-1:0]     out_left_reg, out_left_next;
    logic signed [COORD_BITS-1:0]     out_right_reg, out_right_next;
    logic [gic_pkg::STATUS_BITS-1:0]  out_status_reg, out_status_next;
    logic                             out_last_reg, out_last_next;

    // Segment store and chosen-cover memory
    logic signed [COORD_BITS-1:0] store_left_mem  [MAX_SEGMENTS];
    logic signed [COORD_BITS-1:0] store_right_mem [MAX_SEGMENTS];
    logic signed [COORD_BITS-1:0] cover_left_mem  [gic_pkg::RESULT_CAP];
    logic signed [COORD_BITS-1:0] cover_right_mem [gic_pkg::RESULT_CAP];
    logic signed [COORD_BITS-1:0] rd_left_reg, rd_right_reg;
    logic signed [COORD_BITS-1:0] cv_left_reg, cv_right_reg;

    // ------------------------------------------------------------------
    // Combinational signals
    // ------------------------------------------------------------------
    logic                         accept;
    logic                         out_free;
    logic                         store_we;
    logic                         cover_we;
    logic signed [CMP_W-1:0]      tgt_cmp;
    logic signed [CMP_W-1:0]      left_cmp;
    logic signed [CMP_W-1:0]      reach_cmp;
    logic                         is_start;
    logic                         is_storable;
    gic_pkg::scan_ctl_t           scan_ctl;
    logic                         best_have;
    logic signed [COORD_BITS-1:0] best_left;
    logic signed [COORD_BITS-1:0] best_right;
    logic [gic_pkg::STATUS_BITS-1:0] run_status;

    assign accept   = seg.valid && seg.ready;
    assign out_free = !out_valid_reg || result.ready;

    assign tgt_cmp   = CMP_W'($signed({1'b0, target_reg}));
    assign left_cmp  = CMP_W'(seg.seg_left);
    assign reach_cmp = CMP_W'(reach_reg);

    // Classify the incoming segment: a start segment contains 0, a storable
    // one neither lies wholly right of the target nor wholly left of 0
    assign is_start    = (seg.seg_left <= 0) && (seg.seg_right >= 0);
    assign is_storable = !is_start && !(left_cmp > tgt_cmp) && !(seg.seg_right < 0);

    assign run_status = ovfl_reg ? gic_pkg::ST_OVERFLOW : gic_pkg::ST_COVER;

    // Shared compare unit: sees one store entry per cycle during a scan
    gic_scan #(
        .COORD_BITS (COORD_BITS)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (scan_ctl),
        .reach      (reach_reg),
        .cand_left  (rd_left_reg),
        .cand_right (rd_right_reg),
        .have       (best_have),
        .best_left  (best_left),
        .best_right (best_right)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        start_found_next = start_found_reg;
        start_left_next  = start_left_reg;
        start_right_next = start_right_reg;
        ovfl_next        = ovfl_reg;
        reach_next       = reach_reg;
        n_next           = n_reg;
        k_next           = k_reg;
        scan_idx_next    = scan_idx_reg;
        rd_pend_next     = 1'b0;
        out_valid_next   = out_valid_reg && !result.ready;
        out_left_next    = out_left_reg;
        out_right_next   = out_right_reg;
        out_status_next  = out_status_reg;
        out_last_next    = out_last_reg;
        store_we         = 1'b0;
        cover_we         = 1'b0;
        scan_ctl.clear   = 1'b0;
        scan_ctl.sample  = rd_pend_reg;
        seg.ready        = 1'b0;

        case (state_reg)
            gic_pkg::S_LOAD:
            begin
                seg.ready = 1'b1;
                if (accept)
                begin
                    if (is_start)
                    begin
                        // Keep the furthest-reaching start; first seen wins ties
                        if (!start_found_reg || (seg.seg_right > start_right_reg))
                        begin
                            start_found_next = 1'b1;
                            start_left_next  = seg.seg_left;
                            start_right_next = seg.seg_right;
                        end
                    end
                    else if (is_storable)
                    begin
                        if (count_reg < CNT_W'(MAX_SEGMENTS))
                        begin
                            store_we   = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            ovfl_next = 1'b1;
                        end
                    end
                    if (seg.last_segment)
                    begin
                        n_next     = '0;
                        reach_next = start_right_next;
                        state_next = start_found_next ? gic_pkg::S_CHECK : gic_pkg::S_FAIL;
                    end
                end
            end

            gic_pkg::S_CHECK:
            begin
                if (reach_cmp < tgt_cmp)
                begin
                    scan_idx_next  = '0;
                    scan_ctl.clear = 1'b1;
                    state_next     = gic_pkg::S_SCAN;
                end
                else
                begin
                    state_next = gic_pkg::S_EMIT_START;
                end
            end

            gic_pkg::S_SCAN:
            begin
                // Issue one store read per cycle; the registered data reaches the unit in the next cycle
                if (scan_idx_reg < count_reg)
                begin
                    rd_pend_next  = 1'b1;
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end
                else if (!rd_pend_reg)
                begin
                    state_next = gic_pkg::S_DECIDE;
                end
            end

            gic_pkg::S_DECIDE:
            begin
                if (!best_have || (best_right <= reach_reg) ||
                    (n_reg == CB'(gic_pkg::RESULT_CAP - 1)))
                begin
                    state_next = gic_pkg::S_FAIL;
                end
                else
                begin
                    cover_we   = 1'b1;
                    n_next     = n_reg + CB'(1);
                    reach_next = best_right;
                    state_next = gic_pkg::S_CHECK;
                end
            end

            gic_pkg::S_EMIT_START:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_left_next   = start_left_reg;
                    out_right_next  = start_right_reg;
                    out_status_next = run_status;
                    out_last_next   = (n_reg == '0);
                    k_next          = '0;
                    if (n_reg == '0)
                    begin
                        count_next       = '0;
                        start_found_next = 1'b0;
                        start_left_next  = '0;
                        start_right_next = '0;
                        ovfl_next        = 1'b0;
                        state_next       = gic_pkg::S_LOAD;
                    end
                    else
                    begin
                        state_next = gic_pkg::S_EMIT_RD;
                    end
                end
            end

            gic_pkg::S_EMIT_RD:
            begin
                // Wait for the cover memory read at k
                state_next = gic_pkg::S_EMIT_WR;
            end

            gic_pkg::S_EMIT_WR:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_left_next   = cv_left_reg;
                    out_right_next  = cv_right_reg;
                    out_status_next = run_status;
                    out_last_next   = (k_reg == n_reg - CB'(1));
                    k_next          = k_reg + CB'(1);
                    if (k_reg == n_reg - CB'(1))
                    begin
                        count_next       = '0;
                        start_found_next = 1'b0;
                        start_left_next  = '0;
                        start_right_next = '0;
                        ovfl_next        = 1'b0;
                        state_next       = gic_pkg::S_LOAD;
                    end
                    else
                    begin
                        state_next = gic_pkg::S_EMIT_RD;
                    end
                end
            end

            gic_pkg::S_FAIL:
            begin
                // No start, a gap, or too many steps: one no-solution beat
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_left_next    = '0;
                    out_right_next   = '0;
                    out_status_next  = gic_pkg::ST_NONE;
                    out_last_next    = 1'b1;
                    count_next       = '0;
                    start_found_next = 1'b0;
                    start_left_next  = '0;
                    start_right_next = '0;
                    ovfl_next        = 1'b0;
                    state_next       = gic_pkg::S_LOAD;
                end
            end

            default:
            begin
                state_next = gic_pkg::S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= gic_pkg::S_LOAD;
            target_reg      <= gic_pkg::TARGET_RESET;
            count_reg       <= '0;
            start_found_reg <= 1'b0;
            start_left_reg  <= '0;
            start_right_reg <= '0;
            ovfl_reg        <= 1'b0;
            n_reg           <= '0;
            k_reg           <= '0;
            scan_idx_reg    <= '0;
            rd_pend_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            start_found_reg <= start_found_next;
            start_left_reg  <= start_left_next;
            start_right_reg <= start_right_next;
            ovfl_reg        <= ovfl_next;
            n_reg           <= n_next;
            k_reg           <= k_next;
            scan_idx_reg    <= scan_idx_next;
            rd_pend_reg     <= rd_pend_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_wr_en)
            begin
                target_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        reach_reg      <= reach_next;
        out_left_reg   <= out_left_next;
        out_right_reg  <= out_right_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    // Segment store: write at the fill count, registered read at the scan index
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_left_mem[count_reg[AW-1:0]]  <= seg.seg_left;
            store_right_mem[count_reg[AW-1:0]] <= seg.seg_right;
        end
        rd_left_reg  <= store_left_mem[scan_idx_reg[AW-1:0]];
        rd_right_reg <= store_right_mem[scan_idx_reg[AW-1:0]];
    end

    // Chosen cover segments in order of reach
    always_ff @(posedge clk)
    begin
        if (cover_we)
        begin
            cover_left_mem[n_reg]  <= best_left;
            cover_right_mem[n_reg] <= best_right;
        end
        cv_left_reg  <= cover_left_mem[k_reg];
        cv_right_reg <= cover_right_mem[k_reg];
    end

    assign result.valid       = out_valid_reg;
    assign result.cover_left  = out_left_reg;
    assign result.cover_right = out_right_reg;
    assign result.status      = out_status_reg;
    assign result.last_result = out_last_reg;

endmodule

// ===== src/gic_checker.sv =====
// Port checker for the greedy interval cover block, bound to the top level.
// Depends on gic_pkg for status codes.
module gic_checker #(
    parameter int COORD_BITS = gic_pkg::COORD_BITS_DEF
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              in_last,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [COORD_BITS-1:0]      out_left,
    input logic signed [COORD_BITS-1:0]      out_right,
    input logic [gic_pkg::STATUS_BITS-1:0]   out_status,
    input logic                              out_last
);

    // A no-solution beat ends the run and carries zero coordinates
    a_none_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_status == gic_pkg::ST_NONE)) |->
            (out_last && (out_left == '0) && (out_right == '0)))
        else $error("no-solution beat not alone or not zero");

    // Only a final beat may report no solution
    a_mid_cover: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_last) |-> (out_status != gic_pkg::ST_NONE))
        else $error("no-solution status on a non-final beat");

    // The final segment starts the computation: input closes next cycle
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_last) |=> !in_ready)
        else $error("input ready right after the final segment");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(out_left) && $stable(out_right) &&
             $stable(out_status) && $stable(out_last)))
        else $error("result changed while stalled");

endmodule

bind greedy_interval_cover gic_checker #(
    .COORD_BITS (COORD_BITS)
) u_gic_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (seg.valid),
    .in_ready   (seg.ready),
    .in_last    (seg.last_segment),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_left   (result.cover_left),
    .out_right  (result.cover_right),
    .out_status (result.status),
    .out_last   (result.last_result)
);

// ===== tb/sv/tb.sv =====
// Testbench for greedy_interval_cover: segment sets in, cover beats out, checked in order.
// Depends on gic_pkg, the seg_if/cover_if interfaces and the greedy_interval_cover RTL.
`timescale 1ns / 1ps

module tb;

    localparam int CW        = gic_pkg::COORD_BITS_DEF;
    localparam int STORE_CAP = gic_pkg::MAX_SEGMENTS_DEF;
    localparam int ITEM_GOAL = 420;
    localparam int CALM_FROM = 360;   // no idling once more than this many beats went in
    localparam int CFG_GAP   = 8;     // settle cycles before a target write

    typedef struct {
        logic signed [CW-1:0]            left;
        logic signed [CW-1:0]            right;
        logic [gic_pkg::STATUS_BITS-1:0] status;
        logic                            last;
    } cover_beat_t;

    typedef struct {
        int l;
        int r;
    } seg_t;

    // Cover predictor and the queue of cover beats it still waits for.
    class cover_scoreboard;
        int          target;
        int          seg_l[STORE_CAP];
        int          seg_r[STORE_CAP];
        int          seg_count;
        int          start_l;
        int          start_r;
        bit          start_seen;
        bit          overflowed;
        cover_beat_t expected_q[$];
        int          mismatches;

        function void clear_set();
            seg_count  = 0;
            start_l    = 0;
            start_r    = 0;
            start_seen = 0;
            overflowed = 0;
        endfunction

        function void set_target(int v);
            target = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void add_expected(int l, int r, logic [gic_pkg::STATUS_BITS-1:0] st,
                                   bit last);
            cover_beat_t b;
            b.left     = l[CW-1:0];
            b.right    = r[CW-1:0];
            b.status   = st;
            b.last     = last;
            expected_q = {expected_q, b};
        endfunction

        // Fold one accepted segment into the set; on the final one, predict the run.
        function void note_segment(logic signed [CW-1:0] lv, logic signed [CW-1:0] rv,
                                   bit last);
            int l;
            int r;
            int reach;
            int picks[gic_pkg::RESULT_CAP];
            int n;
            int best;
            bit have;
            bit ok;
            logic [gic_pkg::STATUS_BITS-1:0] st;
            l = lv;
            r = rv;
            if (l <= 0 && r >= 0)
            begin
                if (!start_seen || r > start_r)
                begin
                    start_l    = l;
                    start_r    = r;
                    start_seen = 1;
                end
            end
            else if (!(l > target || r < 0))
            begin
                if (seg_count < STORE_CAP)
                begin
                    seg_l[seg_count] = l;
                    seg_r[seg_count] = r;
                    seg_count++;
                end
                else
                    overflowed = 1;
            end
            if (!last)
                return;
            if (!start_seen)
            begin
                add_expected(0, 0, gic_pkg::ST_NONE, 1'b1);
                clear_set();
                return;
            end
            reach = start_r;
            n     = 0;
            ok    = 1;
            while (reach < target)
            begin
                have = 0;
                best = 0;
                for (int i = 0; i < seg_count; i++)
                begin
                    if (seg_l[i] > reach)
                        continue;
                    if (!have || seg_r[i] > seg_r[best] ||
                        (seg_r[i] == seg_r[best] && seg_l[i] > seg_l[best]))
                    begin
                        best = i;
                        have = 1;
                    end
                end
                if (!have || seg_r[best] <= reach || n + 1 >= gic_pkg::RESULT_CAP)
                begin
                    ok = 0;
                    break;
                end
                picks[n] = best;
                n++;
                reach = seg_r[best];
            end
            if (!ok)
            begin
                add_expected(0, 0, gic_pkg::ST_NONE, 1'b1);
                clear_set();
                return;
            end
            st = overflowed ? gic_pkg::ST_OVERFLOW : gic_pkg::ST_COVER;
            add_expected(start_l, start_r, st, n == 0);
            for (int k = 0; k < n; k++)
                add_expected(seg_l[picks[k]], seg_r[picks[k]], st, k + 1 == n);
            clear_set();
        endfunction

        function void check_beat(cover_beat_t got);
            cover_beat_t exp_b;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected cover beat: left %0d right %0d status %0d last %0d",
                             got.left, got.right, got.status, got.last);
                return;
            end
            exp_b = expected_q.pop_front();
            if (got.left !== exp_b.left || got.right !== exp_b.right ||
                got.status !== exp_b.status || got.last !== exp_b.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"cover beat mismatch: exp [%0d,%0d] st %0d last %0d,",
                              " got [%0d,%0d] st %0d last %0d"},
                             exp_b.left, exp_b.right, exp_b.status, exp_b.last,
                             got.left, got.right, got.status, got.last);
            end
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_wr_en;
    logic [gic_pkg::TARGET_BITS-1:0] cfg_wr_data;

    seg_if   seg_ch ();
    cover_if cover_ch ();

    greedy_interval_cover u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .seg         (seg_ch),
        .result      (cover_ch)
    );

    cover_scoreboard sb;
    bit              idle_on = 1'b1;   // random gaps and stalls allowed
    int              items_sent = 0;
    seg_t            set_q[$];         // segments of the set being built

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #4_000_000;
        $display("** greedy_interval_cover: FAILED **");
        $finish;
    end

    // Push one segment beat; hold valid until the block takes it.
    task automatic send_beat(input int l, input int r, input bit last);
        logic signed [CW-1:0] lv;
        logic signed [CW-1:0] rv;
        lv = l[CW-1:0];
        rv = r[CW-1:0];
        // Drop valid for a random burst now and then, so gaps land between any two beats.
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            seg_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        seg_ch.valid        <= 1'b1;
        seg_ch.seg_left     <= lv;
        seg_ch.seg_right    <= rv;
        seg_ch.last_segment <= last;
        do
            @(posedge clk);
        while (seg_ch.ready !== 1'b1);
        sb.note_segment(lv, rv, last);
        items_sent++;
    endtask

    // Send the whole set, the final beat flagged, then drop valid and wait for the next clock edge
    // so the next set never raises valid in the step that lowered it.
    task automatic send_set();
        for (int i = 0; i < set_q.size(); i++)
            send_beat(set_q[i].l, set_q[i].r, i == set_q.size() - 1);
        seg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Change target_end only with the block idle: every cover beat back, then the CFG_GAP settle wait.
    task automatic write_target(input int v);
        if (v == sb.target)
            return;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (CFG_GAP) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v[gic_pkg::TARGET_BITS-1:0];
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_target(v & 32'hFFFF);
    endtask

    task automatic add_seg(input int l, input int r);
        seg_t s;
        s.l   = l;
        s.r   = r;
        set_q = {set_q, s};
    endtask

    task automatic shuffle_set();
        seg_t tmp;
        int   j;
        for (int i = set_q.size() - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            tmp      = set_q[i];
            set_q[i] = set_q[j];
            set_q[j] = tmp;
        end
    endtask

    // Build a mostly well-formed chain: a start segment, links that each reach further,
    // tie twins and noise; sometimes a link or the start is left out to open a gap.
    task automatic build_chain_set(input int t);
        int pts[$];
        int steps_goal;
        int step;
        int p;
        int lo;
        int hi;
        int skip;
        int l;
        set_q.delete();
        steps_goal = $urandom_range(1, 6);
        step       = t / (steps_goal + 1);
        if (step < 1)
            step = 1;
        p   = $urandom_range(0, step);
        pts = {pts, p};
        while (p < t)
        begin
            if (pts.size() >= 10)
                p = t;
            else
                p = p + $urandom_range(1, 2 * step);
            if (p > 65535)
                p = 65535;
            pts = {pts, p};
        end
        if ($urandom_range(0, 9) != 0)
            add_seg(-$urandom_range(0, 50), pts[0]);
        skip = -1;
        if (pts.size() > 1 && $urandom_range(0, 6) == 0)
            skip = $urandom_range(1, pts.size() - 1);
        for (int j = 1; j < pts.size(); j++)
        begin
            if (j == skip)
                continue;
            lo = (j >= 2) ? pts[j-2] + 1 : 1;
            hi = pts[j-1];
            if (hi < lo)
                hi = lo;
            l = $urandom_range(lo, hi);
            add_seg(l, pts[j]);
            // Same reach, equal or smaller left: the scan must keep the larger left.
            if ($urandom_range(0, 3) == 0)
                add_seg(l - $urandom_range(0, 3), pts[j]);
        end
        repeat ($urandom_range(0, 4))
        begin
            l = $urandom_range(0, t + 20) - 10;
            add_seg(l, l + $urandom_range(0, t / 2 + 5) - 3);
        end
        if (set_q.size() == 0)
            add_seg($urandom_range(0, 20) - 10, $urandom_range(0, 20) - 10);
        shuffle_set();
    endtask

    // Unit links [i, i+1] after a start at 1: links steps reach links+1.
    task automatic build_ladder_set(input int links);
        set_q.delete();
        add_seg(-$urandom_range(0, 5), 1);
        for (int i = 1; i <= links; i++)
            add_seg(i, i + 1);
        shuffle_set();
    endtask

    // Cover sink: stall in random bursts, check every beat taken.
    initial
    begin : sink
        cover_beat_t got;
        int          stall_left;
        stall_left = 0;
        cover_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (cover_ch.valid === 1'b1 && cover_ch.ready === 1'b1)
            begin
                got.left   = cover_ch.cover_left;
                got.right  = cover_ch.cover_right;
                got.status = cover_ch.status;
                got.last   = cover_ch.last_result;
                sb.check_beat(got);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                cover_ch.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 8) - 1;
                cover_ch.ready <= 1'b0;
            end
            else
                cover_ch.ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        int set_no;
        int kind;
        int t;
        int pick;
        sb = new();
        sb.clear_set();
        sb.set_target(gic_pkg::TARGET_RESET);
        sb.mismatches = 0;

        rst_n               <= 1'b0;
        cfg_wr_en           <= 1'b0;
        cfg_wr_data         <= '0;
        seg_ch.valid        <= 1'b0;
        seg_ch.seg_left     <= '0;
        seg_ch.seg_right    <= '0;
        seg_ch.last_segment <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- Directed part, target at its reset value of 1 ----
        // No start segment: a single no-solution beat.
        set_q.delete();
        add_seg(5, 10);
        send_set();
        // Widest possible segment, both coordinate extremes; the start alone covers.
        set_q.delete();
        add_seg(-65536, 65535);
        send_set();
        // Reversed segment with extreme ends: right < 0, so dropped; no start.
        set_q.delete();
        add_seg(65535, -65536);
        send_set();
        // Two starts with the same reach: the first one seen wins.
        set_q.delete();
        add_seg(-2, 5);
        add_seg(-7, 5);
        send_set();

        // Target of zero: any start covers it alone.
        write_target(0);
        set_q.delete();
        add_seg(0, 0);
        send_set();

        // Largest target: reversed entry in the store, a tie on reach, then the last link.
        write_target(65535);
        set_q.delete();
        add_seg(-1, 10);
        add_seg(5, 2);
        add_seg(3, 40000);
        add_seg(10, 40000);
        add_seg(40000, 65535);
        send_set();

        // Segments wholly right of the target or left of 0 are dropped; then a gap.
        write_target(100);
        set_q.delete();
        add_seg(101, 200);
        add_seg(-5, -1);
        add_seg(0, 50);
        add_seg(60, 100);
        send_set();
        set_q.delete();
        add_seg(-3, 20);
        add_seg(15, 30);
        add_seg(25, 100);
        send_set();

        // ---- Random part ----
        set_no = 0;
        while (items_sent < ITEM_GOAL)
        begin
            // Run the tail with both sides at full rate.
            if (items_sent > CALM_FROM)
                idle_on = 1'b0;
            set_no++;
            kind = $urandom_range(0, 99);
            if (set_no == 3)
            begin
                // Longest cover the block can give: start plus 63 links, 64 beats.
                write_target(64);
                build_ladder_set(63);
            end
            else if (set_no == 9)
            begin
                // One link too many: answered as no solution.
                write_target(65);
                build_ladder_set(64);
            end
            else if (set_no == 15)
            begin
                // Overfill the store; covers of this set carry the overflow status.
                write_target(100);
                set_q.delete();
                add_seg(-2, $urandom_range(0, 10));
                repeat ($urandom_range(66, 68))
                begin
                    t = $urandom_range(1, 100);
                    add_seg(t, t + $urandom_range(0, 30));
                end
            end
            else if (kind < 65)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 5)
                    t = $urandom_range(1, 200);
                else if (pick < 8)
                    t = $urandom_range(1, 65535);
                else if (pick == 8)
                    t = 65535;
                else
                    t = 1;
                write_target(t);
                build_chain_set(t);
            end
            else if (kind < 85)
            begin
                // Raw noise over all coordinate bits and a random target.
                write_target($urandom & 32'hFFFF);
                set_q.delete();
                repeat ($urandom_range(1, 8))
                    add_seg($urandom, $urandom);
            end
            else
            begin
                // Short, dense segments around a small target.
                write_target($urandom_range(1, 20));
                set_q.delete();
                repeat ($urandom_range(3, 12))
                begin
                    t = $urandom_range(0, 30) - 5;
                    add_seg(t, t + $urandom_range(0, 12) - 2);
                end
            end
            send_set();
        end

        // Drain: every predicted beat back, then a quiet window to catch strays.
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.mismatches == 0)
            $display("** greedy_interval_cover: PASSED **");
        else
            $display("** greedy_interval_cover: FAILED **");
        $finish;
    end

endmodule
